// ===== src/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared constants, types and the rotate function of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

   typedef logic [31:0] word_type;

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LengthPos = 6'd56;

   // controller commands to the datapath
   typedef struct packed {
      logic       absorb;     // write req byte at fill position
      logic       pad_write;  // write padding byte at fill position
      logic [7:0] pad_byte;
      logic       len_write;  // write length bytes 56..63
      logic       start;      // load working vars, begin rounds
      logic       round;      // run one round
      logic       finish;     // add working vars into chain
      logic       msg_reset;  // restore initial hash, clear fill and length counters
      logic       shift_out;  // rotate chain for digest output
   } dp_cmd_type;

   typedef struct packed {
      logic [6:0] fill;       // bytes in current block, 0..64
      logic       last_round; // round 63 in progress
   } dp_sts_type;

   localparam word_type InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type rotr(input word_type v, input int unsigned amt);
      rotr = (v >> amt) | (v << (32 - amt));
   endfunction

endpackage

// ===== src/sha256_if.sv =====
// ----------------------------------------------------------------------------
// SHA-256 channel interfaces
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha256_req_if (input logic clock);
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;
   modport source (output valid, data_byte, byte_present, end_of_message,
                   input ready);
   modport sink (input valid, data_byte, byte_present, end_of_message,
                 output ready);
endinterface

interface sha256_rsp_if (input logic clock);
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_number;
   logic        final_word;
   modport source (output valid, digest_word, word_number, final_word,
                   input ready);
   modport sink (input valid, digest_word, word_number, final_word,
                 output ready);
endinterface

// ===== src/sha256_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block store, message schedule window, round unit, chain value, counters.
// ----------------------------------------------------------------------------
module sha256_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sha256_pkg::dp_cmd_type cmd,
   input  logic [7:0]             req_byte,
   output sha256_pkg::dp_sts_type sts,
   output sha256_pkg::word_type   head_word
);
   sha256_pkg::word_type store_ff [16];
   sha256_pkg::word_type sched_ff [16];
   sha256_pkg::word_type sched_in [16];
   sha256_pkg::word_type work_ff [8];
   sha256_pkg::word_type work_in [8];
   sha256_pkg::word_type chain_ff [8];
   logic [6:0]           fill_ff;
   logic [6:0]           fill_in;
   logic [5:0]           round_ff;
   logic [63:0]          len_ff;
   logic [63:0]          len_in;
   logic [4:0]           lane_lsb;

   sha256_pkg::word_type s0, s1, w_new, big0, big1, ch, maj, t1, t2;

   assign sts.fill       = fill_ff;
   assign sts.last_round = (round_ff == 6'd63);
   assign head_word      = chain_ff[0];
   assign lane_lsb       = {~fill_ff[1:0], 3'b000};

   always_comb begin
      s0 = sha256_pkg::rotr(sched_ff[1], 7) ^ sha256_pkg::rotr(sched_ff[1], 18)
         ^ (sched_ff[1] >> 3);
      s1 = sha256_pkg::rotr(sched_ff[14], 17) ^ sha256_pkg::rotr(sched_ff[14], 19)
         ^ (sched_ff[14] >> 10);
      w_new = sched_ff[0] + s0 + sched_ff[9] + s1;
      big1 = sha256_pkg::rotr(work_ff[4], 6) ^ sha256_pkg::rotr(work_ff[4], 11)
           ^ sha256_pkg::rotr(work_ff[4], 25);
      ch   = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      t1   = work_ff[7] + big1 + ch + sha256_pkg::RoundConst[round_ff] + sched_ff[0];
      big0 = sha256_pkg::rotr(work_ff[0], 2) ^ sha256_pkg::rotr(work_ff[0], 13)
           ^ sha256_pkg::rotr(work_ff[0], 22);
      maj  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
           ^ (work_ff[1] & work_ff[2]);
      t2   = big0 + maj;
      for (int i = 0; i < 15; i++) sched_in[i] = sched_ff[i + 1];
      sched_in[15] = w_new;
      work_in[7] = work_ff[6];
      work_in[6] = work_ff[5];
      work_in[5] = work_ff[4];
      work_in[4] = work_ff[3] + t1;
      work_in[3] = work_ff[2];
      work_in[2] = work_ff[1];
      work_in[1] = work_ff[0];
      work_in[0] = t1 + t2;
      fill_in = fill_ff;
      len_in  = len_ff;
      if (cmd.absorb) begin
         fill_in = fill_ff + 7'd1;
         len_in  = len_ff + 64'd8;
      end else if (cmd.pad_write) begin
         fill_in = fill_ff + 7'd1;
      end else if (cmd.len_write) begin
         fill_in = 7'd64;
      end else if (cmd.finish) begin
         fill_in = 7'd0;
      end
      if (cmd.msg_reset) begin
         fill_in = 7'd0;
         len_in  = 64'd0;
      end
   end

   // block store write, big-endian byte lanes
   always_ff @(posedge clock) begin
      if (cmd.absorb) store_ff[fill_ff[5:2]][lane_lsb +: 8] <= req_byte;
      else if (cmd.pad_write) store_ff[fill_ff[5:2]][lane_lsb +: 8] <= cmd.pad_byte;
      else if (cmd.len_write) begin
         store_ff[14] <= len_ff[63:32];
         store_ff[15] <= len_ff[31:0];
      end
   end

   // schedule window and working variables
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sched_ff <= store_ff;
         for (int i = 0; i < 8; i++) work_ff[i] <= chain_ff[i];
      end else if (cmd.round) begin
         sched_ff <= sched_in;
         work_ff  <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= 7'd0;
         len_ff   <= 64'd0;
         round_ff <= 6'd0;
         chain_ff <= sha256_pkg::InitHash;
      end else begin
         fill_ff <= fill_in;
         len_ff  <= len_in;
         if (cmd.start) round_ff <= 6'd0;
         else if (cmd.round) round_ff <= round_ff + 6'd1;
         if (cmd.msg_reset) chain_ff <= sha256_pkg::InitHash;
         else if (cmd.finish) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + work_ff[i];
         end else if (cmd.shift_out) begin
            for (int i = 0; i < 7; i++) chain_ff[i] <= chain_ff[i + 1];
            chain_ff[7] <= chain_ff[0];
         end
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 7'd64) else $error("fill count beyond block");
   a_round_after_start: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> round_ff == 6'd0) else $error("round counter not cleared");
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && !cmd.msg_reset |=> fill_ff == 7'd0) else $error("fill not cleared");
endmodule

// ===== src/sha256_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences absorb, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_byte_present,
   input  logic                   req_end_of_message,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_word_number,
   output sha256_pkg::dp_cmd_type cmd,
   input  sha256_pkg::dp_sts_type sts
);
   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StRounds = 3'd1;
   localparam logic [2:0] StPad    = 3'd2;
   localparam logic [2:0] StLen    = 3'd3;
   localparam logic [2:0] StOut    = 3'd4;
   localparam logic [2:0] StFirst  = 3'd5;
   localparam logic [2:0] StAdd    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       closing_ff, closing_in;  // end pending after current block
   logic       last_blk_ff, last_blk_in; // block being compressed is final
   logic       padded_ff, padded_in;    // pad marker byte already written
   logic [2:0] word_ff, word_in;
   logic       accept;

   assign req_ready       = (state_ff == StIdle);
   assign accept          = req_valid && req_ready;
   assign rsp_valid       = (state_ff == StOut);
   assign rsp_word_number = word_ff;

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      closing_in  = closing_ff;
      last_blk_in = last_blk_ff;
      padded_in   = padded_ff;
      word_in     = word_ff;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               cmd.absorb = req_byte_present;
               closing_in = req_end_of_message;
               if (req_byte_present && sts.fill == 7'd63) begin
                  last_blk_in = 1'b0;
                  state_in    = StFirst;
               end else if (req_end_of_message) begin
                  state_in = StFirst;
               end
            end
         end
         StFirst: begin
            // block full: compress; else begin padding
            if (sts.fill == 7'd64) begin
               cmd.start = 1'b1;
               state_in  = StRounds;
            end else begin
               cmd.pad_write = 1'b1;
               cmd.pad_byte  = sha256_pkg::PadByte;
               padded_in     = 1'b1;
               state_in      = StPad;
            end
         end
         StPad: begin
            if (sts.fill == 7'd64) begin
               last_blk_in = 1'b0;
               cmd.start   = 1'b1;
               state_in    = StRounds;
            end else if (sts.fill == {1'b0, sha256_pkg::LengthPos}) begin
               cmd.len_write = 1'b1;
               last_blk_in   = 1'b1;
               state_in      = StLen;
            end else begin
               cmd.pad_write = 1'b1;
               cmd.pad_byte  = 8'h00;
            end
         end
         StLen: begin
            cmd.start = 1'b1;
            state_in  = StRounds;
         end
         StRounds: begin
            cmd.round = 1'b1;
            if (sts.last_round) state_in = StAdd;
         end
         StAdd: begin
            cmd.finish = 1'b1;
            state_in   = StIdle;
            if (last_blk_ff) begin
               state_in = StOut;
               word_in  = 3'd0;
            end else if (closing_ff) begin
               state_in = padded_ff ? StPad : StFirst;
            end
         end
         StOut: begin
            if (rsp_ready) begin
               cmd.shift_out = 1'b1;
               word_in       = word_ff + 3'd1;
               if (word_ff == 3'd7) begin
                  cmd.msg_reset = 1'b1;
                  closing_in    = 1'b0;
                  last_blk_in   = 1'b0;
                  padded_in     = 1'b0;
                  state_in      = StIdle;
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= StIdle;
         closing_ff  <= 1'b0;
         last_blk_ff <= 1'b0;
         padded_ff   <= 1'b0;
         word_ff     <= 3'd0;
      end else begin
         state_ff    <= state_in;
         closing_ff  <= closing_in;
         last_blk_ff <= last_blk_in;
         padded_ff   <= padded_in;
         word_ff     <= word_in;
      end
   end

   a_out_word_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> word_ff == 3'd0) else $error("digest not at word 0");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == StRounds |-> !req_ready) else $error("ready during rounds");
   a_finish_after_rounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == StAdd |-> $past(state_ff) == StRounds) else $error("stray finish");
endmodule

// ===== src/sha256_message_hasher_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher core
// Byte-stream SHA-256: controller sequences a one-round-per-cycle datapath.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | data_byte[7:0], byte_present, end_of_message
//  rsp     | out | digest_word[31:0], word_number[2:0], final_word
//
//  Bytes are taken while req_ready is high; every 64th byte starts compression
//  (one round per cycle in the shared round unit, then the chain add).
//  End of message adds padding (one byte per cycle) and one or two blocks.
//  Reset is synchronous; digest words hold while rsp_ready is low.
module sha256_message_hasher_core (
   input logic         clock,
   input logic         reset,
   sha256_req_if.sink  req,
   sha256_rsp_if.source rsp
);
   sha256_pkg::dp_cmd_type cmd;
   sha256_pkg::dp_sts_type sts;
   sha256_pkg::word_type   head_word;

   sha256_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req.valid),
      .req_byte_present   (req.byte_present),
      .req_end_of_message (req.end_of_message),
      .req_ready          (req.ready),
      .rsp_valid          (rsp.valid),
      .rsp_ready          (rsp.ready),
      .rsp_word_number    (rsp.word_number),
      .cmd                (cmd),
      .sts                (sts)
   );

   sha256_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_byte  (req.data_byte),
      .sts       (sts),
      .head_word (head_word)
   );

   assign rsp.digest_word = head_word;
   assign rsp.final_word  = (rsp.word_number == 3'd7);
endmodule
